FILE: rtl/his_pkg.sv
package his_pkg;

  // Item selector codes
  typedef enum logic [1:0] {
    FUNC_START  = 2'd0,
    FUNC_SAMPLE = 2'd1,
    FUNC_REPORT = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  // Duty fraction is Q0.16
  localparam int DUTY_BITS = 16;

  localparam int COUNT_BITS = 32;
  localparam int SUM_BITS   = 64;

endpackage

FILE: rtl/high_interval_statistics.sv
// Start, plain samples and ignored beats finish in S_IDLE; a sample that closes an interval also
// passes S_SQUARE, S_ACC_SUM, S_ACC_SQ (square, two passes through the shared saturating adder).
// A report passes those, then S_DIV_SETUP, the restoring duty divider and S_OUT; the divider is
// skipped when no time has elapsed or the duty saturates. Throughput: one beat per cycle for
// start and plain samples; in_ready is low while busy. A finished report waits in the output
// register while new beats are accepted. Reset (rst, sync, active high): stats cleared, empty.
module high_interval_statistics import his_pkg::*; #(
  parameter int TIME_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            func,
  input  logic                  level,
  input  logic [31:0]           now,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  level_now,
  output logic [COUNT_BITS-1:0] interval_count,
  output logic [SUM_BITS-1:0]   total_high,
  output logic [SUM_BITS-1:0]   sum_squares,
  output logic [31:0]           shortest,
  output logic [31:0]           longest,
  output logic [DUTY_BITS-1:0]  duty_q16
);

  localparam int TB      = TIME_BITS;
  localparam int SQ_BITS = 2 * TIME_BITS;
  localparam int CNT_W   = $clog2(DUTY_BITS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQUARE,
    S_ACC_SUM,
    S_ACC_SQ,
    S_DIV_SETUP,
    S_DIV,
    S_OUT
  } state_t;

  state_t state;

  // Monitor state
  logic                  held_level;
  logic [TB-1:0]         rise_time;
  logic [TB-1:0]         begin_time;
  logic [COUNT_BITS-1:0] closed_count;
  logic [SUM_BITS-1:0]   duration_sum;
  logic [SUM_BITS-1:0]   square_sum;
  logic [31:0]           min_duration;
  logic [31:0]           max_duration;

  // Working registers
  logic                  is_report;
  logic [TB-1:0]         dur;
  logic [TB-1:0]         elapsed;
  logic [SQ_BITS-1:0]    sq;
  logic [SUM_BITS-1:0]   total;
  logic [SUM_BITS-1:0]   sqs;
  logic [TB-1:0]         rem;
  logic [DUTY_BITS-1:0]  quo;
  logic [CNT_W-1:0]      div_cnt;

  logic [TB-1:0]         now_t;
  logic [TB-1:0]         rise_span;
  logic [TB-1:0]         begin_span;
  logic [31:0]           dur32;
  logic [SUM_BITS-1:0]   add_a;
  logic [SUM_BITS-1:0]   add_b;
  logic [SUM_BITS:0]     add_full;
  logic [SUM_BITS-1:0]   add_sat;
  logic [TB:0]           rem_sh;
  logic [TB:0]           rem_diff;
  logic                  rem_ge;
  logic                  accept;
  logic                  out_free;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Timestamp differences wrap modulo 2^TIME_BITS
  assign now_t      = now[TB-1:0];
  assign rise_span  = now_t - rise_time;
  assign begin_span = now_t - begin_time;
  assign dur32      = 32'(dur);

  // Shared saturating 64-bit adder: duration sum first, square sum next
  assign add_a    = (state == S_ACC_SUM) ? duration_sum : square_sum;
  assign add_b    = (state == S_ACC_SUM) ? SUM_BITS'(dur) : SUM_BITS'(sq);
  assign add_full = {1'b0, add_a} + {1'b0, add_b};
  assign add_sat  = add_full[SUM_BITS] ? '1 : add_full[SUM_BITS-1:0];

  // One restoring division step
  assign rem_sh   = {rem, 1'b0};
  assign rem_diff = rem_sh - {1'b0, elapsed};
  assign rem_ge   = (rem_sh >= {1'b0, elapsed});

  // Sequencer, state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      held_level   <= 1'b0;
      rise_time    <= '0;
      begin_time   <= '0;
      closed_count <= '0;
      duration_sum <= '0;
      square_sum   <= '0;
      min_duration <= '1;
      max_duration <= '0;
    end else begin
      // S_OUT reloads the output register itself
      if (out_valid && out_ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (func_t'(func))
              FUNC_START: begin
                closed_count <= '0;
                duration_sum <= '0;
                square_sum   <= '0;
                min_duration <= '1;
                max_duration <= '0;
                held_level   <= level;
                rise_time    <= now_t;
                begin_time   <= now_t;
              end
              FUNC_SAMPLE: begin
                held_level <= level;
                if (level && !held_level) begin
                  rise_time <= now_t;
                end else if (!level && held_level) begin
                  // falling edge closes the interval
                  dur       <= rise_span;
                  is_report <= 1'b0;
                  state     <= S_SQUARE;
                end
              end
              FUNC_REPORT: begin
                dur       <= held_level ? rise_span : '0;
                elapsed   <= begin_span;
                is_report <= 1'b1;
                state     <= S_SQUARE;
              end
              default: begin
              end
            endcase
          end
        end
        S_SQUARE: begin
          sq    <= dur * dur;
          state <= S_ACC_SUM;
        end
        S_ACC_SUM: begin
          if (is_report) begin
            total <= add_sat;
          end else begin
            duration_sum <= add_sat;
            if (closed_count != '1) begin
              closed_count <= closed_count + COUNT_BITS'(1);
            end
            if (dur32 < min_duration) begin
              min_duration <= dur32;
            end
            if (dur32 > max_duration) begin
              max_duration <= dur32;
            end
          end
          state <= S_ACC_SQ;
        end
        S_ACC_SQ: begin
          if (is_report) begin
            sqs   <= add_sat;
            state <= S_DIV_SETUP;
          end else begin
            square_sum <= add_sat;
            state      <= S_IDLE;
          end
        end
        S_DIV_SETUP: begin
          // no time gone: zero; high time at least elapsed: saturate
          if (elapsed == '0) begin
            quo   <= '0;
            state <= S_OUT;
          end else if (total >= SUM_BITS'(elapsed)) begin
            quo   <= '1;
            state <= S_OUT;
          end else begin
            rem     <= total[TB-1:0];
            quo     <= '0;
            div_cnt <= '0;
            state   <= S_DIV;
          end
        end
        S_DIV: begin
          if (rem_ge) begin
            rem <= rem_diff[TB-1:0];
          end else begin
            rem <= rem_sh[TB-1:0];
          end
          quo     <= {quo[DUTY_BITS-2:0], rem_ge};
          div_cnt <= div_cnt + CNT_W'(1);
          if (div_cnt == CNT_W'(DUTY_BITS - 1)) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid      <= 1'b1;
            level_now      <= held_level;
            interval_count <= closed_count;
            total_high     <= total;
            sum_squares    <= sqs;
            shortest       <= min_duration;
            longest        <= max_duration;
            duty_q16       <= quo;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
